// ===== hdl/h264aub_pkg.sv =====
// Package: scan state codes, NAL type codes and header masks for the AU boundary detector.
`timescale 1ns / 1ps
package h264aub_pkg;

  localparam int unsigned ScanW = 4;

  // Scan state codes
  localparam logic [ScanW-1:0] ScanZero3  = 4'd0;   // three or more zeros seen
  localparam logic [ScanW-1:0] ScanZero2  = 4'd1;   // two zeros seen
  localparam logic [ScanW-1:0] ScanZero1  = 4'd2;   // one zero seen
  localparam logic [ScanW-1:0] ScanHdr3   = 4'd4;   // header after 00 00 01
  localparam logic [ScanW-1:0] ScanHdr4   = 4'd5;   // header after 00 00 00 01
  localparam logic [ScanW-1:0] ScanIdle   = 4'd7;   // hunting for a zero byte
  localparam logic [ScanW-1:0] ScanLast   = 4'd13;  // highest meaningful code
  localparam logic [ScanW-1:0] ScanSlcOfs = 4'd8;   // header -> second-slice test
  localparam logic [ScanW-1:0] ScanToggle = 4'd5;   // zero count -> header on 01
  localparam logic [2:0]       BackMask   = 3'd5;

  // NAL unit types
  localparam logic [4:0] NalSliceNonIdr = 5'd1;
  localparam logic [4:0] NalSlicePartA  = 5'd2;
  localparam logic [4:0] NalSliceIdr    = 5'd5;
  localparam logic [4:0] NalSei         = 5'd6;
  localparam logic [4:0] NalSps         = 5'd7;
  localparam logic [4:0] NalPps         = 5'd8;
  localparam logic [4:0] NalAud         = 5'd9;

  localparam logic [7:0] NalTypeMask = 8'h1F;
  localparam logic [7:0] FirstMbMask = 8'h80;

endpackage

// ===== hdl/h264_access_unit_boundary_detector_top.sv =====
// Top level: H.264 Annex B access unit boundary detector, one byte per word.
//
//   channel   dir  tdata                       tuser           tlast
//   s_axis    in   [7:0] data_byte             -               end_of_stream
//   m_axis    out  [2:0] boundary_back, pad 0  boundary_found  stream_closed
//
// Throughput is one byte per clock while the output is not stalled; the result
// word is registered in the output register on input acceptance. The byte is
// decoded against the scan state in one short combinational step and the state
// updates on accept. Reset puts the scan in the idle hunt with no frame started.
// A stalled output holds its word; the input is taken whenever the output
// register is empty or being drained in the same cycle.
`timescale 1ns / 1ps
module h264_access_unit_boundary_detector_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // end_of_stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [2:0] boundary_back, [7:3] zero
  output logic       m_axis_tuser_o,   // boundary_found
  output logic       m_axis_tlast_o    // stream_closed
);
  import h264aub_pkg::*;

  logic [ScanW-1:0] scan_q, scan_d;
  logic             frame_q, frame_d;
  logic             out_vld_q, out_vld_d;
  logic [2:0]       back_q, back_d;
  logic             found_q, found_d;
  logic             closed_q, closed_d;

  logic             in_acc;
  logic [ScanW-1:0] s_cur;
  logic [4:0]       nal_type;
  logic             ends_frame, is_slice;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign s_cur    = (scan_q > ScanLast) ? ScanIdle : scan_q;
  assign nal_type = 5'(s_axis_tdata_i & NalTypeMask);

  always_comb begin
    ends_frame = 1'b0;
    is_slice   = 1'b0;
    case (nal_type)
      NalSliceNonIdr: begin
        ends_frame = 1'b1;
        is_slice   = 1'b1;
      end
      NalSlicePartA, NalSliceIdr: begin
        is_slice = 1'b1;
      end
      NalSei, NalSps, NalPps, NalAud: begin
        ends_frame = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next scan state, frame flag and result for the byte on the input.
  always_comb begin
    scan_d  = s_cur;
    frame_d = frame_q;
    found_d = 1'b0;
    back_d  = 3'd0;
    if (s_axis_tlast_i) begin
      scan_d  = ScanIdle;
      frame_d = 1'b0;
    end else if (s_cur == ScanIdle) begin
      if (s_axis_tdata_i == 8'd0) begin
        scan_d = ScanZero1;
      end
    end else if (s_cur <= ScanZero1) begin
      if (s_axis_tdata_i == 8'd1) begin
        scan_d = s_cur ^ ScanToggle;
      end else if (s_axis_tdata_i != 8'd0) begin
        scan_d = ScanIdle;
      end else begin
        scan_d = s_cur >> 1;
      end
    end else if (s_cur <= ScanHdr4) begin
      if (ends_frame && frame_q) begin
        found_d = 1'b1;
        back_d  = (s_cur[2:0] & BackMask) - 3'd1;
        frame_d = (nal_type == NalSliceNonIdr);
        scan_d  = ScanIdle;
      end else if (is_slice && frame_q) begin
        scan_d = s_cur + ScanSlcOfs;
      end else begin
        if (is_slice) begin
          frame_d = 1'b1;
        end
        scan_d = ScanIdle;
      end
    end else begin
      // second slice: first_mb_in_slice == 0 opens a new unit
      if ((s_axis_tdata_i & FirstMbMask) != 8'd0) begin
        found_d = 1'b1;
        back_d  = s_cur[2:0] & BackMask;
        frame_d = 1'b1;
      end
      scan_d = ScanIdle;
    end
  end

  assign closed_d  = s_axis_tlast_i;
  assign out_vld_d = in_acc ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= ScanIdle;
      frame_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (in_acc) begin
        scan_q  <= scan_d;
        frame_q <= frame_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      found_q  <= found_d;
      back_q   <= back_d;
      closed_q <= closed_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, back_q};
  assign m_axis_tuser_o  = found_q;
  assign m_axis_tlast_o  = closed_q;

  // Checks on the internal logic
  a_eos_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast_i |=> scan_q == ScanIdle && !frame_q)
    else $error("end of stream did not reset the scan");

  a_back_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && found_q |-> back_q == 3'd3 || back_q == 3'd4 || back_q == 3'd5)
    else $error("boundary distance out of range");

  a_no_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !found_q |-> back_q == 3'd0)
    else $error("distance without boundary");

  a_closed_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && closed_q |-> !found_q)
    else $error("boundary reported on end of stream");

  a_found_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && found_d |-> frame_q)
    else $error("boundary without a started frame");

endmodule

// ===== bench/h264_access_unit_boundary_detector_top_tb.sv =====
// Testbench: checks the H.264 access unit boundary detector against its own predictor.
`timescale 1ns / 1ps
module h264_access_unit_boundary_detector_top_tb;
  import h264aub_pkg::*;

  localparam int unsigned IdleLimit = 3000;   // cycles without any accepted word
  localparam int unsigned HoldCycles = 400;   // long output hold-off

  typedef struct packed {
    logic       found;
    logic [2:0] back;
    logic       closed;
  } au_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;  // [7:0] data_byte
  logic       s_axis_tlast_i = 1'b0;   // end_of_stream
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;          // [2:0] boundary_back, [7:3] zero
  logic       m_axis_tuser_o;          // boundary_found
  logic       m_axis_tlast_o;          // stream_closed

  h264_access_unit_boundary_detector_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state
  logic [ScanW-1:0] scan_q = ScanIdle;
  logic             frame_q = 1'b0;

  au_word_t au_expect_q[$];
  int unsigned errors = 0;
  int unsigned n_bytes = 0;
  int unsigned n_eos = 0;
  int unsigned n_results = 0;
  int unsigned n_boundaries = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_req = 0;
  int unsigned hold_cnt = 0;
  int unsigned rx_gap = 0;
  bit          quiet = 1'b0;
  bit          tx_bursty = 1'b1;
  bit          rx_bursty = 1'b1;

  // Advance the scan by one byte and return the word the block should emit.
  function automatic au_word_t predict_au(input logic [7:0] b, input logic eos);
    au_word_t         r;
    logic [ScanW-1:0] s;
    logic [4:0]       t;
    logic             ends_frame;
    logic             is_slice;
    r = '0;
    if (eos) begin
      scan_q  = ScanIdle;
      frame_q = 1'b0;
      r.closed = 1'b1;
      return r;
    end
    s = (scan_q > ScanLast) ? ScanIdle : scan_q;
    if (s == ScanIdle) begin
      if (b == 8'h00) s = ScanZero1;
    end else if (s <= ScanZero1) begin
      if (b == 8'h01) s = s ^ ScanToggle;
      else if (b != 8'h00) s = ScanIdle;
      else s = s >> 1;
    end else if (s <= ScanHdr4) begin
      t = 5'(b & NalTypeMask);
      ends_frame = (t == NalSei) || (t == NalSps) || (t == NalPps) || (t == NalAud) ||
                   (t == NalSliceNonIdr);
      is_slice = (t == NalSliceNonIdr) || (t == NalSlicePartA) || (t == NalSliceIdr);
      if (ends_frame && frame_q) begin
        r.found = 1'b1;
        r.back  = (s[2:0] & BackMask) - 3'd1;
        frame_q = (t == NalSliceNonIdr);
        s = ScanIdle;
      end else if (is_slice && frame_q) begin
        s = s + ScanSlcOfs;
      end else begin
        if (is_slice) frame_q = 1'b1;
        s = ScanIdle;
      end
    end else begin
      // second slice: first_mb_in_slice == 0 shows as a set top bit
      if ((b & FirstMbMask) != 8'h00) begin
        r.found = 1'b1;
        r.back  = s[2:0] & BackMask;
        frame_q = 1'b1;
      end
      s = ScanIdle;
    end
    scan_q = s;
    return r;
  endfunction

  // Offer one word, wait for the handshake and log its expected result.
  task automatic send_word(input logic [7:0] b, input logic eos);
    int unsigned gap;
    if (!quiet && tx_bursty && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eos;
    do @(posedge clk_i); while (!s_axis_tready_o);
    au_expect_q.push_back(predict_au(b, eos));
    if (eos) n_eos++;
    else n_bytes++;
  endtask

  // Drop valid after the last word of a test.
  task automatic pause_input();
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i  <= 1'b0;
    @(posedge clk_i);
  endtask

  // One NAL unit: start code of random length, header, short payload.
  // Some units carry noise or an end of stream.
  task automatic send_nal_unit();
    logic [7:0]  hdr;
    logic [4:0]  nal_type;
    int unsigned zeros;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      send_word(8'($urandom), 1'b1);
      return;
    end
    if (pick <= 2) begin
      // noise: runs of zeros and ones, broken start codes
      len = $urandom_range(1, 5);
      repeat (len) begin
        case ($urandom_range(0, 2))
          0: send_word(8'h00, 1'b0);
          1: send_word(8'h01, 1'b0);
          default: send_word(8'($urandom), 1'b0);
        endcase
      end
    end
    pick = $urandom_range(0, 9);
    zeros = (pick < 6) ? 2 : (pick < 9) ? 3 : $urandom_range(4, 6);
    repeat (zeros) send_word(8'h00, 1'b0);
    send_word(8'h01, 1'b0);
    case ($urandom_range(0, 11))
      0, 1:    nal_type = NalSliceNonIdr;
      2:       nal_type = NalSlicePartA;
      3, 4, 5: nal_type = NalSliceIdr;
      6:       nal_type = NalSei;
      7:       nal_type = NalSps;
      8:       nal_type = NalPps;
      9:       nal_type = NalAud;
      default: nal_type = 5'($urandom);
    endcase
    hdr = {($urandom_range(0, 7) == 0), 2'($urandom), nal_type};
    send_word(hdr, 1'b0);
    len = $urandom_range(1, 6);
    repeat (len) send_word(8'($urandom), 1'b0);
  endtask

  task automatic test_directed();
    logic [7:0] seq[$] = '{
      8'h00, 8'h00, 8'h01, 8'h65,                 // first IDR slice opens a frame
      8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h88,   // second slice, first_mb zero
      8'h00, 8'h00, 8'h01, 8'h41,                 // non-IDR slice ends the frame
      8'h00, 8'h00, 8'h01, 8'h02, 8'h7F,          // second slice, top bit clear
      8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hE7,   // SPS after a long zero run
      8'hFF, 8'h00, 8'h00
    };
    foreach (seq[i]) send_word(seq[i], 1'b0);
    send_word(8'hFF, 1'b1);                       // end of stream mid start code
    send_word(8'h00, 1'b1);
    pause_input();
  endtask

  task automatic test_random_streams(input int unsigned count);
    int unsigned stop_at;
    stop_at = n_bytes + n_eos + count;
    while (n_bytes + n_eos < stop_at) begin
      if ($urandom_range(0, 29) == 0) tx_bursty = !tx_bursty;
      send_nal_unit();
    end
    pause_input();
  endtask

  task automatic test_backpressure();
    int unsigned stop_at;
    hold_req = HoldCycles;
    stop_at = n_bytes + n_eos + 40;
    while (n_bytes + n_eos < stop_at) send_nal_unit();
    pause_input();
  endtask

  task automatic test_steady_stream(input int unsigned count);
    quiet = 1'b1;
    test_random_streams(count);
  endtask

  // Output side: random stall bursts, plus the long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if ($urandom_range(0, 199) == 0) rx_bursty = !rx_bursty;
    if (hold_cnt != 0) begin
      hold_cnt--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && rx_bursty && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 14) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    au_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (au_expect_q.size() == 0) begin
        $display("%0t: unexpected word: tdata=%h tuser=%b tlast=%b", $realtime,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = au_expect_q.pop_front();
        if (want.found) n_boundaries++;
        if (m_axis_tuser_o !== want.found) begin
          $display("%0t: boundary_found expected %b actual %b", $realtime,
                   want.found, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o !== {5'b0, want.back}) begin
          $display("%0t: tdata (boundary_back) expected %h actual %h", $realtime,
                   {5'b0, want.back}, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.closed) begin
          $display("%0t: stream_closed expected %b actual %b", $realtime,
                   want.closed, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding", $realtime,
               IdleLimit, au_expect_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_streams(1050);
    test_backpressure();
    test_steady_stream(300);
    while (au_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d stream bytes and %0d end-of-stream words with random gaps and stalls,",
             n_bytes, n_eos);
    $display("checked %0d results, %0d of them access unit boundaries.",
             n_results, n_boundaries);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
